@@ hdl/fnv_pkg.sv @@
package fnv_pkg;

    // Digest width codes held in the hash_width register.
    localparam logic [1:0] WIDTH_32 = 2'd0;
    localparam logic [1:0] WIDTH_64 = 2'd1;

    // Configuration register indexes.
    localparam logic CFG_HASH_WIDTH = 1'b0;
    localparam logic CFG_XOR_FIRST  = 1'b1;

    // Offset bases.
    localparam logic [31:0] BASIS32     = 32'd2166136261;
    localparam logic [63:0] BASIS64     = 64'd14695981039346656037;
    localparam logic [63:0] BASIS128_LO = 64'h62b821756295c58d;
    localparam logic [63:0] BASIS128_HI = 64'h6c62272e07bb0142;

    // Per-beat control that travels with the byte into the hash step.
    typedef struct packed {
        logic [1:0] hash_width;
        logic       xor_first;
        logic       start_new;
    } fnv_ctrl_t;

    // Multiply by 16777619 = 2^24 + 0x193, modulo 2^32.
    function automatic logic [31:0] mul_prime32(input logic [31:0] x);
        mul_prime32 = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    endfunction

    // Multiply by 1099511628211 = 2^40 + 0x1b3, modulo 2^64.
    function automatic logic [63:0] mul_prime64(input logic [63:0] x);
        mul_prime64 = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                    + (x << 1) + x;
    endfunction

    // Multiply by 2^88 + 0x13b, modulo 2^128.
    function automatic logic [127:0] mul_prime128(input logic [127:0] x);
        mul_prime128 = (x << 88) + (x << 8) + (x << 5) + (x << 4) + (x << 3)
                     + (x << 1) + x;
    endfunction

endpackage

@@ hdl/fnv_hash_engine_unit.sv @@
// Running FNV-1 / FNV-1a hash over a byte stream, 32, 64 or 128 bits wide.
// Input channel: one message byte per beat (data_byte, start_new) on in_valid,
// with in_stall driven back. A beat with start_new set reloads the offset basis
// of the selected width before its byte is absorbed.
// Output channel: one digest per input beat on digest_high/digest_low with
// out_valid, held while out_stall is high. Narrow digests are zero-extended.
// Configuration: cfg_write with cfg_index selects hash_width (0) or xor_first
// (1); writes are to be made by the user only while no beat is in flight,
// which the block does not enforce, and apply from the next byte. Throughput
// is one byte per cycle while the receiver does not stall, set by the
// constant multiply (shift-and-add) in the hash state feedback loop.
// A one-beat input register and the output register let a new byte be taken
// while the previous digest waits; when the receiver stalls with both full,
// in_stall rises and nothing moves. Reset empties both registers, clears the
// configuration to 32-bit FNV-1 and loads the 32-bit offset basis.
module fnv_hash_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_new,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_high,
    output logic [63:0] digest_low,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);
    import fnv_pkg::*;

    logic [1:0]  hash_width_reg;
    logic        xor_first_reg;
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        start_reg;
    logic        out_valid_reg;
    logic [63:0] digest_high_reg;
    logic [63:0] digest_low_reg;
    logic [63:0] hash_high_reg;
    logic [63:0] hash_low_reg;
    logic [63:0] hash_high_next;
    logic [63:0] hash_low_next;
    logic        in_accept;
    logic        advance;
    fnv_ctrl_t   ctrl;

    // Handshake: the held beat moves on whenever the output register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign ctrl.hash_width = hash_width_reg;
    assign ctrl.xor_first  = xor_first_reg;
    assign ctrl.start_new  = start_reg;

    fnv_step u_step (
        .hash_high      (hash_high_reg),
        .hash_low       (hash_low_reg),
        .data_byte      (byte_reg),
        .ctrl           (ctrl),
        .hash_high_next (hash_high_next),
        .hash_low_next  (hash_low_next)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_width_reg <= WIDTH_32;
            xor_first_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HASH_WIDTH: hash_width_reg <= cfg_data;
                CFG_XOR_FIRST:  xor_first_reg  <= cfg_data[0];
                default:        hash_width_reg <= hash_width_reg;
            endcase
        end
    end

    // Control state: beat valid flags and the running hash.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hash_high_reg <= BASIS128_HI;
            hash_low_reg  <= {32'd0, BASIS32};
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                hash_high_reg <= hash_high_next;
                hash_low_reg  <= hash_low_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg  <= data_byte;
            start_reg <= start_new;
        end
        if (advance)
        begin
            digest_high_reg <= hash_width_reg[1] ? hash_high_next : 64'd0;
            digest_low_reg  <= hash_low_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_high = digest_high_reg;
    assign digest_low  = digest_low_reg;

endmodule

@@ hdl/fnv_step.sv @@
module fnv_step (
    input  logic [63:0]       hash_high,
    input  logic [63:0]       hash_low,
    input  logic [7:0]        data_byte,
    input  fnv_pkg::fnv_ctrl_t ctrl,
    output logic [63:0]       hash_high_next,
    output logic [63:0]       hash_low_next
);
    import fnv_pkg::*;

    logic [127:0] x128;
    logic [127:0] m128;
    logic [63:0]  x64;
    logic [63:0]  m64;
    logic [31:0]  x32;
    logic [31:0]  m32;

    // Each width folds the byte in before or after the prime multiply.
    always_comb
    begin
        x128 = ctrl.start_new ? {BASIS128_HI, BASIS128_LO} : {hash_high, hash_low};
        x64  = ctrl.start_new ? BASIS64 : hash_low;
        x32  = ctrl.start_new ? BASIS32 : hash_low[31:0];

        if (ctrl.xor_first)
        begin
            m128 = mul_prime128(x128 ^ {120'd0, data_byte});
            m64  = mul_prime64(x64 ^ {56'd0, data_byte});
            m32  = mul_prime32(x32 ^ {24'd0, data_byte});
        end
        else
        begin
            m128 = mul_prime128(x128) ^ {120'd0, data_byte};
            m64  = mul_prime64(x64) ^ {56'd0, data_byte};
            m32  = mul_prime32(x32) ^ {24'd0, data_byte};
        end

        // Bit 1 alone selects the wide datapath; the narrow widths keep the upper half.
        if (ctrl.hash_width[1])
        begin
            hash_high_next = m128[127:64];
            hash_low_next  = m128[63:0];
        end
        else if (ctrl.hash_width == WIDTH_64)
        begin
            hash_high_next = hash_high;
            hash_low_next  = m64;
        end
        else
        begin
            hash_high_next = hash_high;
            hash_low_next  = {32'd0, m32};
        end
    end

endmodule

@@ bench/fnv_digest_check_pkg.sv @@
package fnv_digest_check_pkg;

    import fnv_pkg::*;

    // Width codes that the design package leaves unnamed.
    localparam logic [1:0] WIDTH_128   = 2'd2;
    localparam logic [1:0] WIDTH_SPARE = 2'd3;

    // FNV primes at each digest width.
    localparam logic [31:0]  PRIME_32  = 32'd16777619;
    localparam logic [63:0]  PRIME_64  = 64'd1099511628211;
    localparam logic [127:0] PRIME_128 = (128'd1 << 88) + 128'h13b;

    // Only this many mismatches are printed in full.
    localparam int REPORT_LIMIT = 10;

    class fnv_digest_scoreboard;
        logic [1:0]   width_code;
        logic         xor_first;
        logic [63:0]  hash_hi;
        logic [63:0]  hash_lo;
        logic [127:0] expected_digests[$];
        int           mismatches;
        int           digests_seen;
        int           bytes_32;
        int           bytes_64;
        int           bytes_128;

        // Mirror of the state that the block holds after reset.
        function new();
            width_code   = WIDTH_32;
            xor_first    = 1'b0;
            hash_hi      = BASIS128_HI;
            hash_lo      = {32'd0, BASIS32};
            mismatches   = 0;
            digests_seen = 0;
            bytes_32     = 0;
            bytes_64     = 0;
            bytes_128    = 0;
        endfunction

        // Only the bits that each register holds are kept.
        function void write_register(logic index, logic [1:0] value);
            if (index == CFG_HASH_WIDTH)
                width_code = value;
            else
                xor_first = value[0];
        endfunction

        // Fold one accepted byte into the running hash and queue the digest it yields.
        function void note_byte(logic [7:0] data, logic start);
            logic [127:0] wide;
            logic [63:0]  v64;
            logic [31:0]  v32;
            if (width_code[1])
            begin
                // Bit 1 alone selects the 128-bit datapath, so the spare code lands here.
                wide = start ? {BASIS128_HI, BASIS128_LO} : {hash_hi, hash_lo};
                if (xor_first)
                    wide = (wide ^ {120'd0, data}) * PRIME_128;
                else
                    wide = (wide * PRIME_128) ^ {120'd0, data};
                hash_hi = wide[127:64];
                hash_lo = wide[63:0];
                bytes_128++;
            end
            else if (width_code == WIDTH_64)
            begin
                // The upper half is left alone at 64 bits.
                v64 = start ? BASIS64 : hash_lo;
                if (xor_first)
                    v64 = (v64 ^ {56'd0, data}) * PRIME_64;
                else
                    v64 = (v64 * PRIME_64) ^ {56'd0, data};
                hash_lo = v64;
                wide    = {64'd0, v64};
                bytes_64++;
            end
            else
            begin
                // Only the low word is used, and it is written back zero-extended.
                v32 = start ? BASIS32 : hash_lo[31:0];
                if (xor_first)
                    v32 = (v32 ^ {24'd0, data}) * PRIME_32;
                else
                    v32 = (v32 * PRIME_32) ^ {24'd0, data};
                hash_lo = {32'd0, v32};
                wide    = {96'd0, v32};
                bytes_32++;
            end
            expected_digests.push_back(wide);
        endfunction

        // Compare one accepted digest with the oldest one still waiting.
        function void check_digest(logic [63:0] high, logic [63:0] low);
            logic [127:0] want;
            if (expected_digests.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected digest beat: high %h low %h", high, low);
            end
            else
            begin
                want = expected_digests.pop_front();
                digests_seen++;
                if (high !== want[127:64] || low !== want[63:0])
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Digest %0d wrong: high expected %h got %h, low expected %h got %h",
                                 digests_seen, want[127:64], high, want[63:0], low);
                end
            end
        endfunction

        function int outstanding();
            return expected_digests.size();
        endfunction
    endclass

endpackage

@@ bench/tb_fnv_hash_engine_unit.sv @@
module tb_fnv_hash_engine_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import fnv_pkg::*;
    import fnv_digest_check_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BYTES   = 160;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        start_new;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest_high;
    logic [63:0] digest_low;
    logic        cfg_write;
    logic        cfg_index;
    logic [1:0]  cfg_data;

    fnv_digest_scoreboard sb;
    bit         quiet;
    int         stall_run = 0;
    int         idle_cycles = 0;
    int         config_writes;
    logic [1:0] width_cycle [4] = '{WIDTH_32, WIDTH_64, WIDTH_128, WIDTH_SPARE};

    fnv_hash_engine_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .start_new   (start_new),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_high (digest_high),
        .digest_low  (digest_low),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Every digest beat that leaves the block is checked at once.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_digest(digest_high, digest_low);
    end

    // Receiver back-pressure: mostly free, short stalls, now and then a long one.
    always @(posedge clk)
    begin
        int r;
        if (!rst_n || quiet)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run = stall_run - 1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                stall_run = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 50);
            end
        end
    end

    // The run is abandoned if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Stalled for %0d cycles with %0d digests outstanding",
                     idle_cycles, sb.outstanding());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sender gap before a beat: usually none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Bytes lean towards the extremes now and then.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hff;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Offer one byte beat and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] data, input logic start);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= data;
        start_new <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(data, start);
    endtask

    // Let every digest come out, then write both registers while the block is idle.
    task automatic drain_and_configure(input logic [1:0] width, input logic xf,
                                       input logic spare_bit);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_HASH_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        cfg_index <= CFG_XOR_FIRST;
        cfg_data  <= {spare_bit, xf};
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_register(CFG_HASH_WIDTH, width);
        sb.write_register(CFG_XOR_FIRST, {spare_bit, xf});
        config_writes += 2;
    endtask

    // Mostly well-formed messages with random content, with some bursts of loose start flags.
    task automatic send_message_stream(input int count);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 64);
                for (k = 0; k < len; k++)
                    send_byte(pick_byte(), k == 0);
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    send_byte(pick_byte(), 1'($urandom_range(0, 1)));
            end
            sent += len;
        end
    endtask

    initial
    begin
        logic [1:0] width;
        logic       xf;
        logic       spare_bit;
        int         ph;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        start_new     = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_HASH_WIDTH;
        cfg_data      = WIDTH_32;
        quiet         = 1'b0;
        config_writes = 0;
        sb            = new();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: the first byte carries on from the 32-bit basis without a start.
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h61, 1'b1);
        send_byte(8'hff, 1'b1);

        // The 64-bit FNV-1a and 128-bit FNV-1 settings in turn, with extreme bytes and starts.
        drain_and_configure(WIDTH_64, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h5a, 1'b0);
        drain_and_configure(WIDTH_128, 1'b0, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'ha5, 1'b0);

        // The spare width code, entered mid-message so the 128-bit state carries over.
        drain_and_configure(WIDTH_SPARE, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h01, 1'b0);

        // Width changes without a start continue from the state as it stands.
        drain_and_configure(WIDTH_32, 1'b1, 1'b0);
        send_byte(8'h80, 1'b0);
        drain_and_configure(WIDTH_64, 1'b0, 1'b0);
        send_byte(8'h7f, 1'b0);
        drain_and_configure(WIDTH_128, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0);

        // Random phases: all settings in order first, then random ones; every fourth runs flat out.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 8)
            begin
                width     = width_cycle[ph % 4];
                xf        = (ph >= 4);
                spare_bit = 1'b0;
            end
            else
            begin
                width     = width_cycle[$urandom_range(0, 3)];
                xf        = 1'($urandom_range(0, 1));
                spare_bit = 1'($urandom_range(0, 1));
            end
            drain_and_configure(width, xf, spare_bit);
            quiet = ((ph % 4) == 3);
            send_message_stream(PHASE_BYTES);
        end

        // Wind down: wait for the last digests, then a short settling time.
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Hashed %0d bytes: %0d at 32 bits, %0d at 64 bits, %0d at 128 bits.",
                 sb.bytes_32 + sb.bytes_64 + sb.bytes_128, sb.bytes_32, sb.bytes_64,
                 sb.bytes_128);
        $display("Compared %0d digests across %0d register writes; %0d mismatches.",
                 sb.digests_seen, config_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/fnv_pkg.sv
hdl/fnv_step.sv
hdl/fnv_hash_engine_unit.sv
bench/fnv_digest_check_pkg.sv
bench/tb_fnv_hash_engine_unit.sv
